FILE: design/vccr_pkg.sv
// shared types, register offsets and constants for the display card control registers
// no dependencies; imported by vccr_core, video_card_control_registers_unit and the testbench

package vccr_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    localparam logic [15:0] OFS_VPAN_LO    = 16'h3844;
    localparam logic [15:0] OFS_VPAN_HI    = 16'h3846;
    localparam logic [15:0] OFS_HPAN       = 16'h3848;
    localparam logic [15:0] OFS_IRQ        = 16'h385c;
    localparam logic [15:0] OFS_CLUT_ADDR  = 16'h3a00;
    localparam logic [15:0] OFS_CLUT_DATA  = 16'h3a01;
    localparam logic [15:0] OFS_PARAM_DATA = 16'h3c00;
    localparam logic [15:0] OFS_PARAM_RST  = 16'h3e02;

    // fixed read-back locations
    localparam logic [15:0] OFS_RD_FF_A = 16'h3826;
    localparam logic [15:0] OFS_RD_FF_B = 16'h382e;
    localparam logic [15:0] OFS_RD_F5_A = 16'h3824;
    localparam logic [15:0] OFS_RD_F5_B = 16'h382c;

    localparam logic [31:0] RD_FF          = 32'h0000_00ff;
    localparam logic [31:0] RD_F5          = 32'hffff_fff5;
    localparam logic [31:0] RD_IRQ_PENDING = 32'h0000_0008;
    localparam logic [31:0] PARAM_RST_KEY  = 32'h0000_0001;

    localparam int unsigned NUM_TIMING = 8;

    // hsync, hstart, hend, htotal, vsync, vstart, vend, vtotal
    localparam logic [15:0] TIMING_RESET [NUM_TIMING] = '{
        16'hffe8, 16'hffc0, 16'hfec0, 16'hfeb4,
        16'hfffd, 16'hffdf, 16'hfcdf, 16'hfcdc
    };

    // low byte offset of each timing word, high byte sits two above
    localparam logic [15:0] TIMING_OFS [NUM_TIMING] = '{
        16'h3804, 16'h3808, 16'h380c, 16'h3810,
        16'h3818, 16'h381c, 16'h3824, 16'h3828
    };

    localparam logic [15:0] TIMING_HI_STEP = 16'd2;

    localparam logic [3:0] SHIFT_SEL_BITS = 4'd2;
    localparam logic [3:0] SHIFT_LAST     = 4'd9;
    localparam logic [3:0] SHIFT_FULL     = 4'd10;

    localparam logic [1:0] SEL_MODE = 2'd0;
    localparam logic [1:0] SEL_HPAN = 2'd1;

    localparam logic [1:0] COLOR_LAST = 2'd2;

    localparam logic signed [15:0] VT_80M   = -16'sd803;
    localparam logic signed [15:0] VT_55M   = -16'sd654;
    localparam logic signed [15:0] VT_30M   = -16'sd525;
    localparam logic signed [15:0] VT_15M   = -16'sd411;
    localparam logic signed [15:0] VT_14M_I = -16'sd262;

    localparam logic [2:0] CLK_64M   = 3'd0;
    localparam logic [2:0] CLK_80M   = 3'd1;
    localparam logic [2:0] CLK_55M   = 3'd2;
    localparam logic [2:0] CLK_30M   = 3'd3;
    localparam logic [2:0] CLK_15M   = 3'd4;
    localparam logic [2:0] CLK_14M_I = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] reg_offset;
        logic [31:0] write_data;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic        pal_write;
        logic [7:0]  pal_index;
        logic [7:0]  pal_red;
        logic [7:0]  pal_green;
        logic [7:0]  pal_blue;
        logic [1:0]  pixel_mode;
        logic        zoom;
        logic        timing_valid;
        logic [2:0]  clock_select;
        logic [10:0] hpan;
    } t_result;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7 - k];
        end
        return r;
    endfunction

endpackage

FILE: design/vccr_core.sv
// register state and single-pass update logic for one bus transaction or tick
// depends on vccr_pkg

module vccr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  vccr_pkg::t_item  i_item,
    output vccr_pkg::t_result o_result
);
    import vccr_pkg::*;

    logic [15:0] r_timing [NUM_TIMING];
    logic [9:0]  r_vpan;
    logic [10:0] r_hpan;
    logic        r_zoom;
    logic [1:0]  r_mode;
    logic        r_vbl_disabled;
    logic        r_vbl_pending;
    logic [1:0]  r_color_count;
    logic [7:0]  r_color_hold [2];
    logic [7:0]  r_table_offset;
    logic [3:0]  r_shift_count;
    logic [1:0]  r_shift_select;
    logic [7:0]  r_shift_value;

    logic [15:0] n_timing [NUM_TIMING];
    logic [9:0]  n_vpan;
    logic [10:0] n_hpan;
    logic        n_zoom;
    logic [1:0]  n_mode;
    logic        n_vbl_disabled;
    logic        n_vbl_pending;
    logic [1:0]  n_color_count;
    logic [7:0]  n_color_hold [2];
    logic [7:0]  n_table_offset;
    logic [3:0]  n_shift_count;
    logic [1:0]  n_shift_select;
    logic [7:0]  n_shift_value;

    logic [7:0]  inv_byte;
    logic        param_bit;
    logic [2:0]  value_pos;
    logic        timing_hit;
    logic [31:0] rd;
    logic        pal_write;
    logic [7:0]  pal_index;
    logic [7:0]  pal_red;
    logic [7:0]  pal_green;
    logic [7:0]  pal_blue;
    logic        timing_valid;
    logic [2:0]  clock_select;

    assign inv_byte  = ~i_item.write_data[7:0];
    assign param_bit = ~i_item.write_data[0];
    assign value_pos = 3'(r_shift_count - SHIFT_SEL_BITS);

    always_comb begin
        n_timing       = r_timing;
        n_vpan         = r_vpan;
        n_hpan         = r_hpan;
        n_zoom         = r_zoom;
        n_mode         = r_mode;
        n_vbl_disabled = r_vbl_disabled;
        n_vbl_pending  = r_vbl_pending;
        n_color_count  = r_color_count;
        n_color_hold   = r_color_hold;
        n_table_offset = r_table_offset;
        n_shift_count  = r_shift_count;
        n_shift_select = r_shift_select;
        n_shift_value  = r_shift_value;
        timing_hit     = 1'b0;
        rd             = '0;
        pal_write      = 1'b0;
        pal_index      = '0;
        pal_red        = '0;
        pal_green      = '0;
        pal_blue       = '0;

        case (t_cmd'(i_item.command))
            CMD_READ: begin
                case (i_item.reg_offset)
                    OFS_RD_FF_A, OFS_RD_FF_B: rd = RD_FF;
                    OFS_RD_F5_A, OFS_RD_F5_B: rd = RD_F5;
                    OFS_VPAN_HI: rd = ~{27'd0, r_zoom, 2'd0, r_vpan[9:8]};
                    OFS_HPAN:    rd = ~{25'd0, r_hpan[10:4]};
                    OFS_IRQ:     rd = r_vbl_pending ? RD_IRQ_PENDING : '0;
                    default:     rd = '0;
                endcase
            end
            CMD_WRITE: begin
                for (int i = 0; i < NUM_TIMING; i++) begin
                    if (i_item.reg_offset == TIMING_OFS[i]) begin
                        n_timing[i][7:0] = i_item.write_data[7:0];
                        timing_hit       = 1'b1;
                    end else if (i_item.reg_offset == TIMING_OFS[i] + TIMING_HI_STEP) begin
                        n_timing[i][15:8] = i_item.write_data[7:0];
                        timing_hit        = 1'b1;
                    end
                end
                if (!timing_hit) begin
                    case (i_item.reg_offset)
                        OFS_VPAN_LO: n_vpan[7:0] = inv_byte;
                        OFS_VPAN_HI: begin
                            n_vpan[9:8] = inv_byte[1:0];
                            n_zoom      = inv_byte[4];
                        end
                        OFS_HPAN: n_hpan[10:4] = inv_byte[6:0];
                        OFS_IRQ: begin
                            if (i_item.write_data[4]) begin
                                n_vbl_disabled = 1'b1;
                                n_vbl_pending  = 1'b0;
                            end else begin
                                n_vbl_disabled = 1'b0;
                            end
                        end
                        OFS_CLUT_ADDR: n_table_offset = inv_byte;
                        OFS_CLUT_DATA: begin
                            if (r_color_count < COLOR_LAST) begin
                                n_color_hold[r_color_count[0]] = inv_byte;
                                n_color_count = r_color_count + 2'd1;
                            end else begin
                                pal_write      = 1'b1;
                                pal_index      = rev8(r_table_offset);
                                pal_red        = r_color_hold[0];
                                pal_green      = r_color_hold[1];
                                pal_blue       = inv_byte;
                                n_table_offset = r_table_offset + 8'd1;
                                n_color_count  = '0;
                            end
                        end
                        OFS_PARAM_DATA: begin
                            if (r_shift_count < SHIFT_SEL_BITS) begin
                                n_shift_select[r_shift_count[0]] = param_bit;
                            end else if (r_shift_count < SHIFT_FULL) begin
                                n_shift_value[value_pos] = param_bit;
                                if (r_shift_count == SHIFT_LAST) begin
                                    if (r_shift_select == SEL_MODE) begin
                                        n_mode = n_shift_value[1:0];
                                    end else if (r_shift_select == SEL_HPAN) begin
                                        n_hpan[3:0] = n_shift_value[6:3];
                                    end
                                end
                            end
                            if (r_shift_count < SHIFT_FULL) begin
                                n_shift_count = r_shift_count + 4'd1;
                            end
                        end
                        OFS_PARAM_RST: begin
                            if (i_item.write_data == PARAM_RST_KEY) begin
                                n_shift_count = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_TICK: begin
                if (!r_vbl_disabled) begin
                    n_vbl_pending = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // timing checks and clock choice on the updated words
    always_comb begin
        timing_valid = ($signed(n_timing[1]) < $signed(n_timing[0])) &&
                       ($signed(n_timing[2]) < $signed(n_timing[1])) &&
                       ($signed(n_timing[3]) < $signed(n_timing[2])) &&
                       ($signed(n_timing[5]) < $signed(n_timing[4])) &&
                       ($signed(n_timing[6]) < $signed(n_timing[5])) &&
                       ($signed(n_timing[7]) < $signed(n_timing[6]));
        case (n_timing[7])
            VT_80M:   clock_select = CLK_80M;
            VT_55M:   clock_select = CLK_55M;
            VT_30M:   clock_select = CLK_30M;
            VT_15M:   clock_select = CLK_15M;
            VT_14M_I: clock_select = CLK_14M_I;
            default:  clock_select = CLK_64M;
        endcase
    end

    always_comb begin
        o_result.read_data    = rd;
        o_result.irq          = n_vbl_pending;
        o_result.pal_write    = pal_write;
        o_result.pal_index    = pal_index;
        o_result.pal_red      = pal_red;
        o_result.pal_green    = pal_green;
        o_result.pal_blue     = pal_blue;
        o_result.pixel_mode   = n_mode;
        o_result.zoom         = n_zoom;
        o_result.timing_valid = timing_valid;
        o_result.clock_select = clock_select;
        o_result.hpan         = n_hpan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing       <= TIMING_RESET;
            r_vpan         <= '0;
            r_hpan         <= '0;
            r_zoom         <= 1'b0;
            r_mode         <= '0;
            r_vbl_disabled <= 1'b1;
            r_vbl_pending  <= 1'b0;
            r_color_count  <= '0;
            r_color_hold   <= '{8'd0, 8'd0};
            r_table_offset <= '0;
            r_shift_count  <= '0;
            r_shift_select <= '0;
            r_shift_value  <= '0;
        end else if (i_fire) begin
            r_timing       <= n_timing;
            r_vpan         <= n_vpan;
            r_hpan         <= n_hpan;
            r_zoom         <= n_zoom;
            r_mode         <= n_mode;
            r_vbl_disabled <= n_vbl_disabled;
            r_vbl_pending  <= n_vbl_pending;
            r_color_count  <= n_color_count;
            r_color_hold   <= n_color_hold;
            r_table_offset <= n_table_offset;
            r_shift_count  <= n_shift_count;
            r_shift_select <= n_shift_select;
            r_shift_value  <= n_shift_value;
        end
    end

endmodule

FILE: design/video_card_control_registers_unit.sv
// top level of the display card control registers: input register, result register, flow control
// depends on vccr_pkg and vccr_core
//
// usage:
//   input channel carries one transaction per item: a bus read, a bus write or a
//   vertical blank tick (i_command, i_reg_offset, i_write_data). it is taken on a
//   rising edge with i_valid high and o_stall low.
//   output channel returns exactly one result per transaction (o_read_data, o_irq,
//   palette write fields and the status fields after the transaction), taken on a
//   rising edge with o_valid high and i_stall low.
//   a transaction passes the input register, then the single update stage and the
//   result register, before o_valid rises. throughput: one transaction per cycle
//   while i_stall is low, set by the single update stage between the two registers.
//   when the receiver stalls, the result register holds and the input register
//   keeps one more transaction; o_stall rises only once both are full.
//   synchronous active-low reset empties both registers and loads the default
//   timing words, interrupt disabled, all other state cleared.

module video_card_control_registers_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_reg_offset,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data,
    output logic        o_irq,
    output logic        o_pal_write,
    output logic [7:0]  o_pal_index,
    output logic [7:0]  o_pal_red,
    output logic [7:0]  o_pal_green,
    output logic [7:0]  o_pal_blue,
    output logic [1:0]  o_pixel_mode,
    output logic        o_zoom,
    output logic        o_timing_valid,
    output logic [2:0]  o_clock_select,
    output logic [10:0] o_hpan
);
    import vccr_pkg::*;

    logic    r_item_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;

    logic    n_item_valid;
    logic    n_out_valid;
    logic    advance;
    logic    accept;
    t_result core_result;

    assign advance      = r_item_valid && (!r_out_valid || !i_stall);
    assign o_stall      = r_item_valid && !advance;
    assign accept       = i_valid && !o_stall;
    assign n_item_valid = o_stall ? 1'b1 : i_valid;
    assign n_out_valid  = advance ? 1'b1 : (r_out_valid && i_stall);

    vccr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_item_valid <= n_item_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.command    <= i_command;
            r_item.reg_offset <= i_reg_offset;
            r_item.write_data <= i_write_data;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_data    = r_out.read_data;
    assign o_irq          = r_out.irq;
    assign o_pal_write    = r_out.pal_write;
    assign o_pal_index    = r_out.pal_index;
    assign o_pal_red      = r_out.pal_red;
    assign o_pal_green    = r_out.pal_green;
    assign o_pal_blue     = r_out.pal_blue;
    assign o_pixel_mode   = r_out.pixel_mode;
    assign o_zoom         = r_out.zoom;
    assign o_timing_valid = r_out.timing_valid;
    assign o_clock_select = r_out.clock_select;
    assign o_hpan         = r_out.hpan;

endmodule

FILE: verif/testbench.sv
// self-checking testbench for video_card_control_registers_unit: directed table, then random
// bus sequences, each result checked against a behavioural model of the register block
// depends on vccr_pkg and the design sources
`timescale 1ns / 100ps

module testbench;
    import vccr_pkg::*;

    localparam logic [1:0] CMD_BAD      = 2'd3;
    localparam int         ZOOM_BIT     = 4;
    localparam int         IRQ_OFF_BIT  = 4;
    localparam int         N_DIRECTED   = 26;
    localparam int         N_RANDOM     = 1000;
    localparam int         GAP_PCT      = 27;
    localparam int         STUCK_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES = 8;

    typedef struct packed {
        t_item       item;
        logic        typed;
        logic [31:0] read_val;
    } t_row;

    localparam t_result RESET_VIEW = '{32'h0, 1'b0, 1'b0, 8'h0, 8'h0, 8'h0, 8'h0,
                                       2'd0, 1'b0, 1'b1, CLK_64M, 11'h0};

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_stall      = 1'b0;
    logic [1:0]  i_command    = CMD_READ;
    logic [15:0] i_reg_offset = 16'h0;
    logic [31:0] i_write_data = 32'h0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_read_data;
    logic        o_irq;
    logic        o_pal_write;
    logic [7:0]  o_pal_index;
    logic [7:0]  o_pal_red;
    logic [7:0]  o_pal_green;
    logic [7:0]  o_pal_blue;
    logic [1:0]  o_pixel_mode;
    logic        o_zoom;
    logic        o_timing_valid;
    logic [2:0]  o_clock_select;
    logic [10:0] o_hpan;

    // register model state
    logic signed [15:0] tw [NUM_TIMING];
    logic [9:0]         vpan_m;
    logic [10:0]        hpan_m;
    logic               zoom_m;
    logic [1:0]         mode_m;
    logic               irq_off_m;
    logic               irq_pend_m;
    logic [1:0]         colour_n;
    logic [7:0]         colour_hold [2];
    logic [7:0]         clut_ofs;
    logic [3:0]         sbit_n;
    logic [1:0]         ssel;
    logic [7:0]         sval;

    t_row    stim_q [$];
    t_result results_due [$];
    int      taken      = 0;
    int      mismatches = 0;
    bit      calm       = 1'b0;

    t_row directed_rows [N_DIRECTED] = '{
        '{'{CMD_READ,  OFS_IRQ,        32'h0},        1'b1, 32'h0},
        '{'{CMD_READ,  OFS_RD_F5_A,    32'h0},        1'b1, RD_F5},
        '{'{CMD_READ,  OFS_RD_FF_B,    32'hffff_ffff}, 1'b1, RD_FF},
        '{'{CMD_READ,  OFS_VPAN_HI,    32'h0},        1'b1, 32'hffff_ffff},
        '{'{CMD_READ,  OFS_HPAN,       32'h0},        1'b1, 32'hffff_ffff},
        '{'{CMD_READ,  16'h0000,       32'h0},        1'b1, 32'h0},
        '{'{CMD_BAD,   16'hffff,       32'hffff_ffff}, 1'b1, 32'h0},
        '{'{CMD_TICK,  16'h0000,       32'h0},        1'b1, 32'h0},
        '{'{CMD_WRITE, OFS_IRQ,        32'h0},        1'b0, 32'h0},
        '{'{CMD_TICK,  16'hffff,       32'hffff_ffff}, 1'b0, 32'h0},
        '{'{CMD_READ,  OFS_IRQ,        32'h0},        1'b0, 32'h0},
        '{'{CMD_WRITE, OFS_IRQ,        32'h0000_0010}, 1'b0, 32'h0},
        '{'{CMD_WRITE, TIMING_OFS[7],  32'h0000_00dd}, 1'b0, 32'h0},
        '{'{CMD_WRITE, TIMING_OFS[7] + TIMING_HI_STEP, 32'hffff_ff7f}, 1'b0, 32'h0},
        '{'{CMD_WRITE, TIMING_OFS[0] + TIMING_HI_STEP, 32'h0},        1'b0, 32'h0},
        '{'{CMD_WRITE, OFS_VPAN_LO,    32'h0},        1'b0, 32'h0},
        '{'{CMD_WRITE, OFS_VPAN_HI,    32'h0},        1'b0, 32'h0},
        '{'{CMD_WRITE, OFS_HPAN,       32'h0},        1'b0, 32'h0},
        '{'{CMD_READ,  OFS_HPAN,       32'h0},        1'b0, 32'h0},
        '{'{CMD_READ,  OFS_VPAN_HI,    32'h0},        1'b0, 32'h0},
        '{'{CMD_WRITE, OFS_CLUT_ADDR,  32'hffff_fffe}, 1'b0, 32'h0},
        '{'{CMD_WRITE, OFS_CLUT_DATA,  32'h0},        1'b0, 32'h0},
        '{'{CMD_WRITE, OFS_CLUT_DATA,  32'hffff_ffff}, 1'b0, 32'h0},
        '{'{CMD_WRITE, OFS_CLUT_DATA,  32'h0000_005a}, 1'b0, 32'h0},
        '{'{CMD_WRITE, OFS_PARAM_RST,  32'hffff_ffff}, 1'b0, 32'h0},
        '{'{CMD_WRITE, 16'h0000,       32'hffff_ffff}, 1'b0, 32'h0}
    };

    video_card_control_registers_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_reg_offset   (i_reg_offset),
        .i_write_data   (i_write_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .o_irq          (o_irq),
        .o_pal_write    (o_pal_write),
        .o_pal_index    (o_pal_index),
        .o_pal_red      (o_pal_red),
        .o_pal_green    (o_pal_green),
        .o_pal_blue     (o_pal_blue),
        .o_pixel_mode   (o_pixel_mode),
        .o_zoom         (o_zoom),
        .o_timing_valid (o_timing_valid),
        .o_clock_select (o_clock_select),
        .o_hpan         (o_hpan)
    );

    function automatic t_result card_step(input t_item it);
        t_result     r;
        logic [31:0] inv;
        logic        hit;
        logic        sbit;
        r   = '0;
        inv = ~it.write_data;
        hit = 1'b0;
        if (it.command == CMD_READ) begin
            case (it.reg_offset)
                OFS_RD_FF_A, OFS_RD_FF_B: r.read_data = RD_FF;
                OFS_RD_F5_A, OFS_RD_F5_B: r.read_data = RD_F5;
                OFS_VPAN_HI: r.read_data = ~{27'd0, zoom_m, 2'b00, vpan_m[9:8]};
                OFS_HPAN:    r.read_data = ~{25'd0, hpan_m[10:4]};
                OFS_IRQ:     r.read_data = irq_pend_m ? RD_IRQ_PENDING : 32'h0;
                default:     r.read_data = 32'h0;
            endcase
        end else if (it.command == CMD_WRITE) begin
            for (int k = 0; k < NUM_TIMING; k++) begin
                if (!hit && it.reg_offset == TIMING_OFS[k]) begin
                    tw[k][7:0] = it.write_data[7:0];
                    hit = 1'b1;
                end else if (!hit && it.reg_offset == TIMING_OFS[k] + TIMING_HI_STEP) begin
                    tw[k][15:8] = it.write_data[7:0];
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                case (it.reg_offset)
                    OFS_VPAN_LO: vpan_m[7:0] = inv[7:0];
                    OFS_VPAN_HI: begin
                        vpan_m[9:8] = inv[1:0];
                        zoom_m = inv[ZOOM_BIT];
                    end
                    // coarse pan loses bit 7 of the inverted byte
                    OFS_HPAN: hpan_m[10:4] = inv[6:0];
                    OFS_IRQ: begin
                        if (it.write_data[IRQ_OFF_BIT]) begin
                            irq_off_m  = 1'b1;
                            irq_pend_m = 1'b0;
                        end else begin
                            irq_off_m = 1'b0;
                        end
                    end
                    OFS_CLUT_ADDR: clut_ofs = inv[7:0];
                    OFS_CLUT_DATA: begin
                        if (colour_n < COLOR_LAST) begin
                            colour_hold[colour_n[0]] = inv[7:0];
                            colour_n = colour_n + 2'd1;
                        end else begin
                            r.pal_write = 1'b1;
                            for (int b = 0; b < 8; b++) begin
                                r.pal_index[b] = clut_ofs[7 - b];
                            end
                            r.pal_red   = colour_hold[0];
                            r.pal_green = colour_hold[1];
                            r.pal_blue  = inv[7:0];
                            clut_ofs = clut_ofs + 8'd1;
                            colour_n = 2'd0;
                        end
                    end
                    OFS_PARAM_DATA: begin
                        sbit = inv[0];
                        if (sbit_n < SHIFT_SEL_BITS) begin
                            ssel[sbit_n[0]] = sbit;
                        end else if (sbit_n < SHIFT_FULL) begin
                            sval[sbit_n - SHIFT_SEL_BITS] = sbit;
                            if (sbit_n == SHIFT_LAST) begin
                                if (ssel == SEL_MODE) begin
                                    mode_m = sval[1:0];
                                end else if (ssel == SEL_HPAN) begin
                                    hpan_m[3:0] = sval[6:3];
                                end
                            end
                        end
                        if (sbit_n < SHIFT_FULL) begin
                            sbit_n = sbit_n + 4'd1;
                        end
                    end
                    OFS_PARAM_RST: begin
                        if (it.write_data == PARAM_RST_KEY) begin
                            sbit_n = 4'd0;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (it.command == CMD_TICK) begin
            if (!irq_off_m) begin
                irq_pend_m = 1'b1;
            end
        end
        r.irq          = irq_pend_m;
        r.pixel_mode   = mode_m;
        r.zoom         = zoom_m;
        r.hpan         = hpan_m;
        r.timing_valid = (tw[1] < tw[0]) && (tw[2] < tw[1]) && (tw[3] < tw[2]) &&
                         (tw[5] < tw[4]) && (tw[6] < tw[5]) && (tw[7] < tw[6]);
        case (tw[7])
            VT_80M:   r.clock_select = CLK_80M;
            VT_55M:   r.clock_select = CLK_55M;
            VT_30M:   r.clock_select = CLK_30M;
            VT_15M:   r.clock_select = CLK_15M;
            VT_14M_I: r.clock_select = CLK_14M_I;
            default:  r.clock_select = CLK_64M;
        endcase
        return r;
    endfunction

    task automatic add_item(input logic [1:0] cmd, input logic [15:0] ofs,
                            input logic [31:0] data);
        t_row row;
        row = '{'{cmd, ofs, data}, 1'b0, 32'h0};
        stim_q.push_back(row);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < GAP_PCT);
    end

    // predict on every accepted transaction, check every returned one
    always @(posedge i_clk) begin
        t_row    row;
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                row = stim_q[taken];
                taken++;
                want = card_step(row.item);
                if (row.typed) begin
                    want = RESET_VIEW;
                    want.read_data = row.read_val;
                end
                results_due.push_back(want);
            end
            if (o_valid && !i_stall) begin
                got = '{o_read_data, o_irq, o_pal_write, o_pal_index, o_pal_red, o_pal_green,
                        o_pal_blue, o_pixel_mode, o_zoom, o_timing_valid, o_clock_select,
                        o_hpan};
                if (results_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected transaction: read_data %h", got.read_data);
                    end
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("mismatch (exp/got): rd %h/%h irq %b/%b pw %b/%b idx %h/%h",
                                     want.read_data, got.read_data, want.irq, got.irq,
                                     want.pal_write, got.pal_write,
                                     want.pal_index, got.pal_index);
                            $display("  rgb %h%h%h/%h%h%h mode %0d/%0d zoom %b/%b tv %b/%b",
                                     want.pal_red, want.pal_green, want.pal_blue,
                                     got.pal_red, got.pal_green, got.pal_blue,
                                     want.pixel_mode, got.pixel_mode, want.zoom, got.zoom,
                                     want.timing_valid, got.timing_valid);
                            $display("  clk %0d/%0d hpan %h/%h",
                                     want.clock_select, got.clock_select,
                                     want.hpan, got.hpan);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        int          k;
        int          n;
        int          useful;
        int          sent;
        int          tv [NUM_TIMING];
        logic [1:0]  sel;
        logic [15:0] w;
        logic [31:0] d;

        for (k = 0; k < NUM_TIMING; k++) begin
            tw[k] = TIMING_RESET[k];
        end
        vpan_m      = '0;
        hpan_m      = '0;
        zoom_m      = 1'b0;
        mode_m      = '0;
        irq_off_m   = 1'b1;
        irq_pend_m  = 1'b0;
        colour_n    = '0;
        colour_hold = '{8'h0, 8'h0};
        clut_ofs    = '0;
        sbit_n      = '0;
        ssel        = '0;
        sval        = '0;

        for (k = 0; k < N_DIRECTED; k++) begin
            stim_q.push_back(directed_rows[k]);
        end

        useful = 0;
        while (useful < N_RANDOM) begin
            n = stim_q.size();
            case ($urandom_range(0, 9))
                0, 1: begin
                    // serial parameter word, sometimes short or overrun
                    if ($urandom_range(0, 3) != 0) begin
                        add_item(CMD_WRITE, OFS_PARAM_RST, PARAM_RST_KEY);
                    end else if ($urandom_range(0, 1)) begin
                        add_item(CMD_WRITE, OFS_PARAM_RST, $urandom());
                    end
                    sel = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1))
                                                     : 2'($urandom_range(2, 3));
                    case ($urandom_range(0, 7))
                        0:       k = $urandom_range(0, 9);
                        1:       k = $urandom_range(11, 13);
                        default: k = 10;
                    endcase
                    for (int j = 0; j < k; j++) begin
                        d = $urandom();
                        if (j < 2) begin
                            d[0] = ~sel[j];
                        end
                        add_item(CMD_WRITE, OFS_PARAM_DATA, d);
                    end
                end
                2, 3: begin
                    if ($urandom_range(0, 1)) begin
                        add_item(CMD_WRITE, OFS_CLUT_ADDR, $urandom());
                    end
                    k = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 3;
                    for (int j = 0; j < k; j++) begin
                        add_item(CMD_WRITE, OFS_CLUT_DATA, $urandom());
                    end
                end
                4: begin
                    // full timing set, mostly descending, vtotal often a known clock
                    case ($urandom_range(0, 5))
                        0:       tv[7] = VT_80M;
                        1:       tv[7] = VT_55M;
                        2:       tv[7] = VT_30M;
                        3:       tv[7] = VT_15M;
                        4:       tv[7] = VT_14M_I;
                        default: tv[7] = 0 - int'($urandom_range(100, 1000));
                    endcase
                    for (k = 6; k >= 4; k--) begin
                        tv[k] = tv[k + 1] + int'($urandom_range(1, 60));
                    end
                    tv[3] = 0 - int'($urandom_range(300, 1200));
                    for (k = 2; k >= 0; k--) begin
                        tv[k] = tv[k + 1] + int'($urandom_range(1, 300));
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        k = $urandom_range(0, 6);
                        if (k != 3) begin
                            tv[k] = tv[k + 1];
                        end
                    end
                    for (k = 0; k < NUM_TIMING; k++) begin
                        w = tv[k][15:0];
                        d = $urandom();
                        d[7:0] = w[7:0];
                        add_item(CMD_WRITE, TIMING_OFS[k], d);
                        d = $urandom();
                        d[7:0] = w[15:8];
                        add_item(CMD_WRITE, TIMING_OFS[k] + TIMING_HI_STEP, d);
                    end
                end
                5: begin
                    k = $urandom_range(0, NUM_TIMING - 1);
                    w = $urandom_range(0, 1) ? TIMING_OFS[k] : TIMING_OFS[k] + TIMING_HI_STEP;
                    add_item(CMD_WRITE, w, $urandom());
                end
                6: begin
                    d = $urandom();
                    d[IRQ_OFF_BIT] = 1'b0;
                    add_item(CMD_WRITE, OFS_IRQ, d);
                    k = $urandom_range(1, 3);
                    for (int j = 0; j < k; j++) begin
                        add_item(CMD_TICK, 16'($urandom()), $urandom());
                    end
                    add_item(CMD_READ, OFS_IRQ, $urandom());
                    if ($urandom_range(0, 1)) begin
                        d = $urandom();
                        d[IRQ_OFF_BIT] = 1'b1;
                        add_item(CMD_WRITE, OFS_IRQ, d);
                        add_item(CMD_TICK, 16'($urandom()), $urandom());
                        add_item(CMD_READ, OFS_IRQ, $urandom());
                    end
                end
                7: begin
                    case ($urandom_range(0, 2))
                        0:       add_item(CMD_WRITE, OFS_VPAN_LO, $urandom());
                        1:       add_item(CMD_WRITE, OFS_VPAN_HI, $urandom());
                        default: add_item(CMD_WRITE, OFS_HPAN, $urandom());
                    endcase
                    add_item(CMD_READ, $urandom_range(0, 1) ? OFS_VPAN_HI : OFS_HPAN,
                             $urandom());
                end
                8: begin
                    k = $urandom_range(0, NUM_TIMING - 1);
                    case ($urandom_range(0, 6))
                        0:       w = TIMING_OFS[k];
                        1:       w = TIMING_OFS[k] + TIMING_HI_STEP;
                        2:       w = OFS_VPAN_HI;
                        3:       w = OFS_HPAN;
                        4:       w = OFS_IRQ;
                        5:       w = OFS_RD_FF_B;
                        default: w = OFS_RD_F5_B;
                    endcase
                    add_item(CMD_READ, w, $urandom());
                end
                default: begin
                    add_item(2'($urandom_range(0, 3)),
                             $urandom_range(0, 1) ? 16'($urandom()) : OFS_PARAM_RST,
                             $urandom());
                    n = stim_q.size();
                end
            endcase
            useful += stim_q.size() - n;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sent = 0;
        while (sent < stim_q.size()) begin
            @(negedge i_clk);
            calm = (sent >= N_DIRECTED + 300) && (sent < N_DIRECTED + 550);
            if (!calm && $urandom_range(0, 99) < GAP_PCT) begin
                i_valid <= 1'b0;
            end else begin
                i_valid      <= 1'b1;
                i_command    <= stim_q[sent].item.command;
                i_reg_offset <= stim_q[sent].item.reg_offset;
                i_write_data <= stim_q[sent].item.write_data;
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
                sent++;
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
